// File: hw/rtl/f2pcm_pkg.sv
package f2pcm_pkg;

    localparam int SampleWidth = 32;
    localparam int PcmWidth    = 32;
    localparam int ModeWidth   = 2;
    localparam int MagWidth    = 41;

    typedef enum logic [ModeWidth-1:0] {
        MODE_PCM16 = 2'd0,
        MODE_PCM24 = 2'd1,
        MODE_PCM32 = 2'd2,
        MODE_NONE  = 2'd3
    } width_mode_t;

endpackage

// File: hw/rtl/f2pcm_convert.sv
module f2pcm_convert (
    input  logic [f2pcm_pkg::SampleWidth-1:0] sample_bits,
    input  f2pcm_pkg::width_mode_t            width_mode,
    output logic [f2pcm_pkg::PcmWidth-1:0]    pcm_value
);
    import f2pcm_pkg::*;

    logic              neg;
    logic [7:0]        expf;
    logic [22:0]       frac;
    logic [23:0]       mant;
    logic [5:0]        wm1;
    logic signed [10:0] k;
    logic [4:0]        s;
    logic [MagWidth-1:0] mag;
    logic [MagWidth-1:0] lim;
    logic [23:0]       q;
    // One bit wider than the mantissa so a shift of 25 keeps its half point.
    logic [24:0]       rem;
    logic [24:0]       half;
    logic [MagWidth-1:0] m;

    always_comb begin
        neg  = sample_bits[31];
        expf = sample_bits[30:23];
        frac = sample_bits[22:0];
        case (width_mode)
            MODE_PCM16: wm1 = 6'd15;
            MODE_PCM24: wm1 = 6'd23;
            default:    wm1 = 6'd31;
        endcase
        lim = {{(MagWidth-1){1'b0}}, 1'b1} << wm1;
        if (expf == 8'd0) begin
            mant = {1'b0, frac};
            k    = 11'sd1 - 11'sd150 + $signed({5'd0, wm1});
        end else begin
            mant = {1'b1, frac};
            k    = $signed({3'd0, expf}) - 11'sd150 + $signed({5'd0, wm1});
        end
        s    = 5'(-k);
        q    = '0;
        rem  = '0;
        half = '0;
        mag  = '0;
        if (mant == 24'd0) begin
            mag = '0;
        end else if (k >= 11'sd17) begin
            mag = lim << 1;
        end else if (k >= 11'sd0) begin
            mag = {{(MagWidth-24){1'b0}}, mant} << k[4:0];
        end else if (k <= -11'sd26) begin
            mag = '0;
        end else begin
            q    = mant >> s;
            rem  = {1'b0, mant} & ((25'd1 << s) - 25'd1);
            half = 25'd1 << (s - 5'd1);
            if (rem > half || (rem == half && q[0])) begin
                q = q + 24'd1;
            end
            mag = {{(MagWidth-24){1'b0}}, q};
        end
        if (expf == 8'hFF) begin
            mag = lim;
        end
        m = mag;
        if (neg) begin
            if (m > lim) begin
                m = lim;
            end
            pcm_value = 32'd0 - m[31:0];
        end else begin
            if (m > lim - 41'd1) begin
                m = lim - 41'd1;
            end
            pcm_value = m[31:0];
        end
        if ((expf == 8'hFF && frac != 23'd0) || width_mode == MODE_NONE) begin
            pcm_value = '0;
        end
    end

endmodule

// File: hw/rtl/float_to_pcm_converter_core.sv
// Pipeline: the input register feeds the converter, whose result is registered for the m_ side.
// Throughput: one sample per cycle while m_tready stays high. When a result
// waits, the input register still holds one more sample, then s_tready drops.
// Reset: aresetn is synchronous, active low; it empties the pipeline and
// sets width_mode to the 16 bit setting.
module float_to_pcm_converter_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_data,   // width_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // sample_bits[31:0]
    input  logic        s_tlast,       // last_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,       // pcm_value[31:0]
    output logic        m_tlast        // last_out
);
    import f2pcm_pkg::*;

    width_mode_t mode_reg;

    // Stage one holds the raw sample; stage two holds the converted result.
    logic        in_valid_reg;
    logic [31:0] in_data_reg;
    logic        in_last_reg;
    logic        out_valid_reg;
    logic [31:0] out_data_reg;
    logic        out_last_reg;
    logic [31:0] pcm_next;
    logic        out_load;
    logic        in_load;

    // The result register loads when it is empty or its transfer completes.
    assign out_load = !out_valid_reg || m_tready;
    // The input register can take a sample when it is empty or empties into stage two.
    assign in_load  = !in_valid_reg || out_load;
    assign s_tready = in_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PCM16;
        end else if (cfg_wr_en) begin
            mode_reg <= width_mode_t'(cfg_wr_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (in_load) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_load) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_load && s_tvalid) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (out_load && in_valid_reg) begin
            out_data_reg <= pcm_next;
            out_last_reg <= in_last_reg;
        end
    end

    f2pcm_convert u_convert (
        .sample_bits (in_data_reg),
        .width_mode  (mode_reg),
        .pcm_value   (pcm_next)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_load |=> in_valid_reg)
        else $error("sample lost in stage one");
`endif

endmodule

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import f2pcm_pkg::*;

    // One expected PCM transfer on the m_ side.
    typedef struct packed {
        logic [31:0] pcm;
        logic        last;
    } pcm_beat_t;

    // Scoreboard: keeps the predicted PCM values in transfer order.
    class pcm_scoreboard;
        pcm_beat_t   pending[$];
        width_mode_t mode;
        int          errors;
        int          checked;

        function new();
            mode    = MODE_PCM16;
            errors  = 0;
            checked = 0;
        endfunction

        // Rounded magnitude of |x| * 2^(w-1); anything huge is pinned at 2^40.
        function logic [63:0] scaled_mag(logic [7:0] expo, logic [22:0] frac, int w);
            logic [63:0] mant, q, rem, half;
            int          k;
            int          s;
            if (expo == 8'd0) begin
                mant = {41'd0, frac};
                k    = -149;
            end else begin
                mant = {40'd0, 1'b1, frac};
                k    = int'(expo) - 150;
            end
            k = k + w - 1;
            if (mant == 64'd0) return 64'd0;
            if (k >= 0) begin
                if (k >= 17) return 64'd1 << 40;
                return mant << k;
            end
            s = -k;
            if (s >= 26) return 64'd0;
            q    = mant >> s;
            rem  = mant & ((64'd1 << s) - 64'd1);
            half = 64'd1 << (s - 1);
            if (rem > half || (rem == half && q[0])) q = q + 64'd1;
            return q;
        endfunction

        function logic [31:0] to_pcm(logic [31:0] bits);
            logic [63:0] lim, m;
            int          w;
            case (mode)
                MODE_PCM16: w = 16;
                MODE_PCM24: w = 24;
                MODE_PCM32: w = 32;
                default:    return 32'd0;
            endcase
            lim = 64'd1 << (w - 1);
            if (bits[30:23] == 8'hFF) begin
                if (bits[22:0] != 23'd0) return 32'd0;
                m = lim;
            end else begin
                m = scaled_mag(bits[30:23], bits[22:0], w);
            end
            if (bits[31]) begin
                if (m > lim) m = lim;
                return 32'd0 - m[31:0];
            end
            if (m > lim - 64'd1) m = lim - 64'd1;
            return m[31:0];
        endfunction

        function void note_sample(logic [31:0] bits, logic last);
            pcm_beat_t b;
            b.pcm  = to_pcm(bits);
            b.last = last;
            pending.push_back(b);
        endfunction

        function void check_result(logic [31:0] pcm, logic last);
            pcm_beat_t b;
            checked++;
            if (pending.size() == 0) begin
                report_mismatch("result transfer with nothing expected", 0, pcm);
                return;
            end
            b = pending.pop_front();
            if (pcm !== b.pcm) report_mismatch("pcm_value", b.pcm, pcm);
            if (last !== b.last) report_mismatch("last_out", b.last, last);
        endfunction

        function void report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
            errors++;
            if (errors <= 50)
                $display("MISMATCH %s: expected %08h got %08h at %0t", what, exp_v, got_v,
                         $realtime);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_wr_data = 2'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    pcm_scoreboard sb = new();
    int            sent = 0;
    int            stall_style = 0;

    always #6 aclk = ~aclk;

    float_to_pcm_converter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

    // Result side: every transfer is checked, and tready follows a stall
    // pattern whose style changes per phase (always ready, sparse, heavy).
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 7) != 0);
            default: m_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    // Send one sample and hold it until the transfer happens. The prediction
    // is taken at the accepting edge, so it always uses the mode then in force.
    task automatic send_sample(logic [31:0] bits, logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= bits;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_sample(bits, last);
        sent++;
    endtask

    task automatic idle_gap(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // Mode changes only with the pipeline drained, after an idle margin.
    task automatic set_mode(width_mode_t m);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.mode = m;
        @(posedge aclk);
    endtask

    // Random sample biased toward audio range, rounding edges and specials.
    function automatic logic [31:0] pick_sample();
        logic [31:0] b;
        b = $urandom();
        case ($urandom_range(0, 9))
            0, 1, 2: b[30:23] = 8'd100 + 8'($urandom_range(0, 27));
            3, 4:    b[30:23] = 8'd126 + 8'($urandom_range(0, 33));
            5:       b[30:23] = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
            6:       b[15:0] = ($urandom_range(0, 1)) ? 16'h0000 : 16'h8000;
            default: ;
        endcase
        return b;
    endfunction

    task automatic random_burst_phase(int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && left > 0) begin
                send_sample(pick_sample(), $urandom_range(0, 1));
                burst--;
                left--;
            end
            if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
        end
    endtask

    logic [31:0] directed_set[] = '{
        32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
        32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFFF_FFFF,
        32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF,
        32'hFF7F_FFFF, 32'h3F00_0000, 32'hBF00_0000, 32'h3F7F_FFFF,
        32'h3800_0000, 32'h3800_4000, 32'h3800_C000, 32'h3380_0000,
        32'h3300_0000, 32'h3400_0000, 32'h4000_0000, 32'h5555_AAAA
    };

    initial begin
        width_mode_t modes[4] = '{MODE_PCM16, MODE_PCM24, MODE_PCM32, MODE_NONE};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed pass in the reset mode first, then under every width mode, the reset mode included.
        foreach (directed_set[i]) send_sample(directed_set[i], i[0]);
        for (int p = 0; p < 4; p++) begin
            set_mode(modes[p]);
            foreach (directed_set[i]) send_sample(directed_set[i], i[1]);
        end

        // Random phases: a random mode with each back-pressure style in turn.
        for (int p = 0; p < 12; p++) begin
            stall_style = p % 3;
            set_mode(modes[$urandom_range(0, 3)]);
            random_burst_phase(100);
        end
        set_mode(MODE_PCM32);
        random_burst_phase(100);

        s_tvalid <= 1'b0;
        stall_style = 1;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);

        $display("Covered %0d samples and %0d results over all width modes,", sent, sb.checked);
        $display("with random sender gaps and receiver stalls.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
